// ===== hdl/i2p_pkg.sv =====
// Package for the infix to postfix converter: character codes, precedence and
// operand helpers, controller state and command/status structs.
// No dependencies; the top level, the datapath and the controller import it.
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CHAR_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CHAR_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_UC_A  = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;  // 'Z'
  localparam logic [7:0] CHAR_LC_A  = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;  // 'z'
  localparam logic [7:0] CHAR_DIG_0 = 8'h30;  // '0'
  localparam logic [7:0] CHAR_DIG_9 = 8'h39;  // '9'

  localparam logic [1:0] PREC_NONE  = 2'd0;
  localparam logic [1:0] PREC_OPEN  = 2'd1;
  localparam logic [1:0] PREC_ADD   = 2'd2;
  localparam logic [1:0] PREC_MUL   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECIDE
  } i2p_state_e;

  // Source of the character placed in the output register.
  typedef enum logic [1:0] {
    SEL_IN_CHAR,
    SEL_TOP,
    SEL_HOLD,
    SEL_NONE
  } i2p_out_sel_e;

  typedef struct packed {
    logic         latch;       // capture the incoming item
    logic         push_in;     // push the incoming character
    logic         push_cur;    // push the captured character
    logic         pop;         // drop the top entry
    logic         hold_load;   // move the top entry into the hold register
    logic         hold_clear;  // mark the hold register empty
    logic         out_load;    // load the output register
    i2p_out_sel_e out_sel;
    logic         out_unm;
    logic         out_term;
    logic         out_last;
  } i2p_cmd_t;

  typedef struct packed {
    logic in_end;       // incoming item is an end item
    logic in_operand;   // incoming character is a letter or digit
    logic in_open;      // incoming character is '('
    logic cur_end;      // captured item is an end item
    logic cur_close;    // captured character is ')'
    logic cnt_zero;     // stack empty
    logic full;         // stack full
    logic top_open;     // top entry is '('
    logic prec_above;   // captured character binds tighter than the top
    logic have_hold;    // hold register carries a popped character
    logic out_free;     // output register can take a result this cycle
  } i2p_status_t;

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c)
      CHAR_OPEN:                p = PREC_OPEN;
      CHAR_PLUS, CHAR_MINUS:    p = PREC_ADD;
      CHAR_MUL, CHAR_DIV:       p = PREC_MUL;
      default:                  p = PREC_NONE;
    endcase
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) ||
           ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ||
           ((c >= CHAR_DIG_0) && (c <= CHAR_DIG_9));
  endfunction

endpackage

// ===== hdl/i2p_in_if.sv =====
// Input channel of the infix to postfix converter: valid/ready handshake and
// one expression character per item. No dependencies.
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_expr;

  modport source (output valid, output in_char, output end_of_expr, input ready);
  modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

// ===== hdl/i2p_out_if.sv =====
// Output channel of the infix to postfix converter: valid/ready handshake and
// one postfix result per item. No dependencies.
interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       char_valid;
  logic       unmatched_close;
  logic       terminator;
  logic       last;

  modport source (output valid, output out_char, output char_valid,
                  output unmatched_close, output terminator, output last,
                  input ready);
  modport sink   (input valid, input out_char, input char_valid,
                  input unmatched_close, input terminator, input last,
                  output ready);
endinterface

// ===== hdl/infix_to_postfix_converter_unit.sv =====
// Top level of the infix to postfix converter: controller and datapath.
// Depends on i2p_pkg, i2p_in_if, i2p_out_if, i2p_ctrl and i2p_datapath.
//
// This block converts an infix expression, taken one character per item, into
// postfix form by the shunting yard method. Letters and digits are passed out
// at once. A '(' is pushed on an operator stack of STACK_DEPTH entries; a
// push into a full stack is dropped. A ')' pops and emits operators until its
// '(' turns up, which is discarded; when none is found the stack is drained
// and the last result of the item carries unmatched_close (a lone result with
// char_valid low when the stack was empty). Any other character pops while
// its precedence ('(' 1, '+' '-' 2, '*' '/' 3, anything else 0) is at most
// that of the top, and is then pushed. An end item drains the stack and ends
// with a terminator result. Every item's final result has last set; '(', an
// operator that pops nothing and a ')' that meets its '(' at once produce no
// result. A letter, digit or '(' is handled in the cycle it is taken; any
// other item passes ST_FETCH before the first stack decision and after each
// popped entry, as the stack memory top is read by a registered port. Results go
// through a one-entry output register, so a waiting result does not stop the
// next item from being taken while that register is being emptied; a stalled
// output holds the pop sequence. The stack needs no clearing after reset.
module infix_to_postfix_converter_unit
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2p_in_if.sink    in_i,
  i2p_out_if.source out_o
);

  i2p_cmd_t    cmd;
  i2p_status_t status;

  // Sequencing of each item: input handshake, pop loop, result requests.
  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Stack storage, captured item, pending popped character and output register.
  i2p_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_char_i     (in_i.in_char),
    .end_of_expr_i (in_i.end_of_expr),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_o         (out_o)
  );

endmodule

// ===== hdl/i2p_datapath.sv =====
// Datapath of the infix to postfix converter: operator stack memory, stack
// count, captured item, hold register and output register. Uses i2p_pkg.
module i2p_datapath
  import i2p_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  in_char_i,
  input  logic        end_of_expr_i,
  input  i2p_cmd_t    cmd_i,
  output i2p_status_t status_o,
  i2p_out_if.source   out_o
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [7:0]    stack_mem [STACK_DEPTH];
  logic [CW-1:0] count_q, count_d;
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          push;
  logic [7:0]    cur_q;
  logic          end_q;
  logic [7:0]    hold_q;
  logic          have_hold_q;
  logic          out_valid_q;
  logic [7:0]    out_char_q;
  logic          char_valid_q, unm_q, term_q, last_q;
  logic [7:0]    sel_char;
  logic          sel_valid;
  logic          out_free;
  logic [CW-1:0] count_m1;

  assign count_m1 = count_q - CW'(1);
  assign rd_addr  = count_m1[AW-1:0];
  assign wr_addr  = count_q[AW-1:0];
  assign push     = cmd_i.push_in | cmd_i.push_cur;
  assign wr_data  = cmd_i.push_in ? in_char_i : cur_q;

  always_comb begin
    count_d = count_q;
    if (push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_m1;
    end
  end

  // Stack memory: one write port at the count, one registered read at the top.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cur_q <= in_char_i;
      end_q <= end_of_expr_i;
    end
    if (cmd_i.hold_load) begin
      hold_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_hold_q <= 1'b0;
    end else if (cmd_i.hold_load) begin
      have_hold_q <= 1'b1;
    end else if (cmd_i.hold_clear) begin
      have_hold_q <= 1'b0;
    end
  end

  always_comb begin
    case (cmd_i.out_sel)
      SEL_IN_CHAR: begin
        sel_char  = in_char_i;
        sel_valid = 1'b1;
      end
      SEL_TOP: begin
        sel_char  = rd_q;
        sel_valid = 1'b1;
      end
      SEL_HOLD: begin
        sel_char  = hold_q;
        sel_valid = 1'b1;
      end
      default: begin
        sel_char  = '0;
        sel_valid = 1'b0;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_char_q   <= sel_char;
      char_valid_q <= sel_valid;
      unm_q        <= cmd_i.out_unm;
      term_q       <= cmd_i.out_term;
      last_q       <= cmd_i.out_last;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_char        = out_char_q;
  assign out_o.char_valid      = char_valid_q;
  assign out_o.unmatched_close = unm_q;
  assign out_o.terminator      = term_q;
  assign out_o.last            = last_q;

  // The character of an end item carries no meaning, so it is never a ')'.
  assign status_o.in_end     = end_of_expr_i;
  assign status_o.in_operand = is_operand(in_char_i);
  assign status_o.in_open    = (in_char_i == CHAR_OPEN);
  assign status_o.cur_end    = end_q;
  assign status_o.cur_close  = !end_q && (cur_q == CHAR_CLOSE);
  assign status_o.cnt_zero   = (count_q == '0);
  assign status_o.full       = (count_q == CW'(STACK_DEPTH));
  assign status_o.top_open   = (rd_q == CHAR_OPEN);
  assign status_o.prec_above = (prec_of(cur_q) > prec_of(rd_q));
  assign status_o.have_hold  = have_hold_q;
  assign status_o.out_free   = out_free;

endmodule

// ===== hdl/i2p_ctrl.sv =====
// Controller of the infix to postfix converter: input handshake and the pop
// sequence over the operator stack. Uses i2p_pkg; drives i2p_datapath.
module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  i2p_status_t status_i,
  output i2p_cmd_t    cmd_o
);

  i2p_state_e state_q, state_d;
  logic       accept;
  logic       is_op;
  logic       stop;

  assign accept = (state_q == ST_IDLE) && in_valid_i && status_i.out_free;
  assign is_op  = !status_i.cur_end && !status_i.cur_close;

  // A pop loop ends on an empty stack, on the matching '(' of a ')', or when
  // the captured operator binds tighter than the top.
  assign stop = status_i.cnt_zero ||
                (status_i.cur_close && status_i.top_open) ||
                (is_op && status_i.prec_above);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (status_i.in_end ||
                       (!status_i.in_operand && !status_i.in_open))) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          state_d = stop ? ST_IDLE : ST_FETCH;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.out_sel = SEL_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = status_i.out_free;
        if (accept) begin
          if (status_i.in_end) begin
            cmd_o.latch = 1'b1;
          end else if (status_i.in_operand) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_IN_CHAR;
            cmd_o.out_last = 1'b1;
          end else if (status_i.in_open) begin
            cmd_o.push_in = !status_i.full;
          end else begin
            cmd_o.latch = 1'b1;
          end
        end
      end
      ST_FETCH: begin
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          if (!stop) begin
            cmd_o.pop = 1'b1;
            if (status_i.cur_end) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = SEL_TOP;
            end else begin
              // The previous popped character is sent once it is known not
              // to be the last one of the item.
              cmd_o.hold_load = 1'b1;
              if (status_i.have_hold) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = SEL_HOLD;
              end
            end
          end else if (status_i.cur_end) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_sel  = SEL_NONE;
            cmd_o.out_term = 1'b1;
            cmd_o.out_last = 1'b1;
          end else begin
            if (status_i.cur_close && !status_i.cnt_zero) begin
              cmd_o.pop = 1'b1;  // discard the matching '('
            end
            if (is_op && !status_i.full) begin
              cmd_o.push_cur = 1'b1;
            end
            if (status_i.have_hold) begin
              cmd_o.out_load   = 1'b1;
              cmd_o.out_sel    = SEL_HOLD;
              cmd_o.out_last   = 1'b1;
              cmd_o.out_unm    = status_i.cur_close && status_i.cnt_zero;
              cmd_o.hold_clear = 1'b1;
            end else if (status_i.cur_close && status_i.cnt_zero) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = SEL_NONE;
              cmd_o.out_unm  = 1'b1;
              cmd_o.out_last = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
